>>> src/fcd_pkg.sv
// Shared constants, codes, control structs and the month table of the date converter.
package fcd_pkg;

  // Calendar and time constants.
  localparam logic [23:0] TICKS_PER_SEC = 24'd10000000;
  localparam logic [15:0] BASE_YEAR     = 16'd1601;
  localparam logic [17:0] DAYS_1Y       = 18'd365;
  localparam logic [17:0] DAYS_4Y       = 18'd1461;
  localparam logic [17:0] DAYS_100Y     = 18'd36524;
  localparam logic [23:0] DAYS_400Y     = 24'd146097;

  // Division passes of the serial divider, in the order they run.
  localparam logic [2:0] PASS_TICK = 3'd0;  // ticks to whole seconds
  localparam logic [2:0] PASS_SEC  = 3'd1;  // remainder is the second
  localparam logic [2:0] PASS_MIN  = 3'd2;  // remainder is the minute
  localparam logic [2:0] PASS_HOUR = 3'd3;  // remainder is the hour
  localparam logic [2:0] PASS_ERA  = 3'd4;  // 400-year periods

  typedef struct packed {
    logic       start;
    logic [2:0] pass;
  } div_cmd_t;

  typedef struct packed {
    logic done;
  } div_sts_t;

  typedef struct packed {
    logic        start;
    logic [17:0] days;
    logic [15:0] year;
  } cal_cmd_t;

  typedef struct packed {
    logic done;
  } cal_sts_t;

  // Divisor of each pass.
  function automatic logic [23:0] pass_divisor(input logic [2:0] pass);
    logic [23:0] d;
    unique case (pass)
      PASS_TICK: d = TICKS_PER_SEC;
      PASS_SEC:  d = 24'd60;
      PASS_MIN:  d = 24'd60;
      PASS_HOUR: d = 24'd24;
      PASS_ERA:  d = DAYS_400Y;
      default:   d = TICKS_PER_SEC;
    endcase
    return d;
  endfunction

  // Number of dividend bits each pass has to shift through.
  function automatic logic [6:0] pass_bits(input logic [2:0] pass);
    logic [6:0] n;
    unique case (pass)
      PASS_TICK: n = 7'd64;
      PASS_SEC:  n = 7'd41;
      PASS_MIN:  n = 7'd35;
      PASS_HOUR: n = 7'd30;
      PASS_ERA:  n = 7'd25;
      default:   n = 7'd64;
    endcase
    return n;
  endfunction

  // Month length for a zero-based month index, February set by the leap flag.
  function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
    logic [4:0] len;
    unique case (idx) inside
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

>>> src/filetime_to_calendar_date_core.sv
// Top level: tick count to calendar date and time of day, with stream handshakes.
//
// Usage:
//   The slave channel takes one 64-bit count of 100 ns ticks since 1601-01-01.
//   The master channel returns one item per input: year, month, day of month,
//   hour, minute and whole second. The fraction of a second is dropped.
//   Work runs through one divider that retires one quotient bit per cycle:
//   passes by 10^7, 60, 60, 24 and 146097 shift through 64, 41, 35, 30 and
//   25 dividend bits. The calendar stage then steps through at
//   most 3 centuries, 24 four-year periods, 3 years and 12 months.
//   A result is offered once the bit-serial divider and the calendar stepper
//   are done; the next item can be accepted in the cycle the result is offered.
//   One item is in work at a time. s_axis_tready is high while the block is
//   waiting for an item, also while a finished result still waits in the
//   output register. If the receiver stalls, the next result waits in the
//   calendar stage until the output register frees, and the block holds.
//   Reset empties the output register and returns all sequencers to idle.
module filetime_to_calendar_date_core
  import fcd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] tick_count
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [15:0] year, [19:16] month,
                                      // [24:20] day_of_month, [29:25] hour,
                                      // [35:30] minute, [41:36] second
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_CAL  = 2'd2;
  localparam logic [1:0] S_WAIT = 2'd3;

  logic [1:0]  st_q;
  logic [2:0]  pass_q;
  logic [5:0]  sec_q, min_q;
  logic [4:0]  hour_q;
  logic [41:0] out_q;
  logic        out_valid_q;

  div_cmd_t    div_cmd;
  div_sts_t    div_sts;
  logic [63:0] div_quo;
  logic [23:0] div_rem;
  cal_cmd_t    cal_cmd;
  cal_sts_t    cal_sts;
  logic [15:0] cal_year;
  logic [3:0]  cal_month;
  logic [4:0]  cal_day;

  logic        in_acc;
  logic        out_free;
  logic        div_next;
  logic        era_done;
  logic [16:0] era_year;

  assign s_axis_tready = (st_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign div_next      = (st_q == S_DIV) && div_sts.done && (pass_q != PASS_ERA);
  assign era_done      = (st_q == S_DIV) && div_sts.done && (pass_q == PASS_ERA);

  // Divider commands: the first pass on acceptance, the rest back to back.
  always_comb begin
    div_cmd.start = in_acc || div_next;
    div_cmd.pass  = in_acc ? PASS_TICK : (pass_q + 3'd1);
  end

  // Year at the start of the 400-year period.
  assign era_year = 17'(div_quo[7:0]) * 17'd400 + 17'(BASE_YEAR);

  always_comb begin
    cal_cmd.start = era_done;
    cal_cmd.days  = div_rem[17:0];
    cal_cmd.year  = era_year[15:0];
  end

  fcd_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .tick_i (s_axis_tdata),
    .sts_o  (div_sts),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  fcd_calendar u_cal (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cal_cmd),
    .sts_o   (cal_sts),
    .year_o  (cal_year),
    .month_o (cal_month),
    .day_o   (cal_day)
  );

  // Time-of-day fields from the divider remainders.
  always_ff @(posedge clk_i) begin
    if (st_q == S_DIV && div_sts.done) begin
      case (pass_q)
        PASS_SEC:  sec_q  <= div_rem[5:0];
        PASS_MIN:  min_q  <= div_rem[5:0];
        PASS_HOUR: hour_q <= div_rem[4:0];
        default: ;
      endcase
    end
  end

  // Item sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      pass_q <= PASS_TICK;
    end else begin
      unique case (st_q)
        S_IDLE: begin
          if (in_acc) begin
            st_q   <= S_DIV;
            pass_q <= PASS_TICK;
          end
        end
        S_DIV: begin
          if (div_next) pass_q <= pass_q + 3'd1;
          if (era_done) st_q   <= S_CAL;
        end
        S_CAL: begin
          if (cal_sts.done) st_q <= S_WAIT;
        end
        S_WAIT: begin
          if (out_free) st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (st_q == S_WAIT && out_free) begin
      out_q <= {sec_q, min_q, hour_q, cal_day, cal_month, cal_year};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (st_q == S_WAIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q};

  // Divider completions arrive only while the sequencer runs the passes.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> st_q == S_DIV)
    else $error("divider done outside division passes");

  // Calendar completions arrive only while the calendar stage is running.
  a_cal_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_sts.done |-> st_q == S_CAL)
    else $error("calendar done outside calendar stage");

  // The pass index stays within the list of passes.
  a_pass_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_DIV |-> pass_q <= PASS_ERA)
    else $error("division pass out of range");

  // A new result appears only as the wait state hands it over.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(st_q) == S_WAIT)
    else $error("result shown without a finished item");

endmodule

>>> src/fcd_serial_div.sv
// Restoring divider by constant divisors, one quotient bit per cycle.
module fcd_serial_div
  import fcd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  div_cmd_t    cmd_i,
  input  logic [63:0] tick_i,
  output div_sts_t    sts_o,
  output logic [63:0] quo_o,
  output logic [23:0] rem_o
);

  logic [63:0] dv_q, dv_d;
  logic [24:0] rem_q, rem_d;
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [2:0]  pass_q;

  logic [23:0] divisor;
  logic [24:0] cand;
  logic        ge;
  logic [6:0]  shamt;

  assign divisor = pass_divisor(pass_q);
  assign shamt   = 7'd64 - pass_bits(cmd_i.pass);

  // One restoring step: shift in the next dividend bit and try the subtract.
  always_comb begin
    cand  = {rem_q[23:0], dv_q[63]};
    ge    = cand >= {1'b0, divisor};
    rem_d = ge ? (cand - {1'b0, divisor}) : cand;
    dv_d  = {dv_q[62:0], ge};
  end

  // Datapath: load the dividend left-aligned, then step until the count runs out.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      dv_q   <= (cmd_i.pass == PASS_TICK) ? tick_i : (dv_q << shamt);
      rem_q  <= '0;
      pass_q <= cmd_i.pass;
    end else if (busy_q) begin
      dv_q  <= dv_d;
      rem_q <= rem_d;
    end
  end

  // Control: step counter and completion flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (cmd_i.start) begin
      cnt_q  <= pass_bits(cmd_i.pass);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign sts_o.done = done_q;
  assign quo_o      = dv_q;
  assign rem_o      = rem_q[23:0];

endmodule

>>> src/fcd_calendar.sv
// Year, month and day from the days left in a 400-year period, by stepped subtraction.
module fcd_calendar
  import fcd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cal_cmd_t    cmd_i,
  output cal_sts_t    sts_o,
  output logic [15:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o
);

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_CENT = 3'd1;
  localparam logic [2:0] C_QUAD = 3'd2;
  localparam logic [2:0] C_YEAR = 3'd3;
  localparam logic [2:0] C_MON  = 3'd4;

  logic [2:0]  st_q;
  logic [17:0] days_q;
  logic [15:0] year_q;
  logic [4:0]  cnt_q;
  logic [1:0]  b_q;
  logic [4:0]  c_q;
  logic [3:0]  mon_q;
  logic [4:0]  day_q;
  logic        done_q;

  logic [17:0] step_days;
  logic [4:0]  step_limit;
  logic [15:0] step_year;
  logic        take;
  logic        leap;
  logic [4:0]  mlen;

  // Period length, cap and year increment of the current stage.
  always_comb begin
    unique case (st_q)
      C_CENT:  begin step_days = DAYS_100Y; step_limit = 5'd3;  step_year = 16'd100; end
      C_QUAD:  begin step_days = DAYS_4Y;   step_limit = 5'd24; step_year = 16'd4;   end
      default: begin step_days = DAYS_1Y;   step_limit = 5'd3;  step_year = 16'd1;   end
    endcase
    take = (days_q >= step_days) && (cnt_q < step_limit);
  end

  // The year is 1601 + 400a + 100b + 4c + d; it is a leap year when d is 3,
  // unless c is 24 too, which makes it a century year that is leap only for b of 3.
  assign leap = (cnt_q[1:0] == 2'd3) && ((c_q != 5'd24) || (b_q == 2'd3));
  assign mlen = month_len(mon_q, leap);

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      C_IDLE: begin
        if (cmd_i.start) begin
          days_q <= cmd_i.days;
          year_q <= cmd_i.year;
        end
      end
      C_CENT, C_QUAD, C_YEAR: begin
        if (take) begin
          days_q <= days_q - step_days;
          year_q <= year_q + step_year;
        end
        if (!take && st_q == C_CENT) b_q <= cnt_q[1:0];
        if (!take && st_q == C_QUAD) c_q <= cnt_q;
      end
      C_MON: begin
        if (days_q < {13'd0, mlen}) begin
          mon_q <= mon_q + 4'd1;
          day_q <= days_q[4:0] + 5'd1;
        end else if (mon_q == 4'd11) begin
          // Past the end of the year: saturate to December 31.
          mon_q <= 4'd12;
          day_q <= 5'd31;
        end else begin
          days_q <= days_q - {13'd0, mlen};
          mon_q  <= mon_q + 4'd1;
        end
      end
      default: ;
    endcase
    if (st_q == C_YEAR && !take) mon_q <= 4'd0;
  end

  // Stage sequencing and the step counter; the counter keeps the single years
  // through the month scan for the leap test.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= C_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (st_q)
        C_IDLE: begin
          if (cmd_i.start) begin
            st_q  <= C_CENT;
            cnt_q <= '0;
          end
        end
        C_CENT, C_QUAD: begin
          if (take) begin
            cnt_q <= cnt_q + 5'd1;
          end else begin
            cnt_q <= '0;
            st_q  <= st_q + 3'd1;
          end
        end
        C_YEAR: begin
          if (take) cnt_q <= cnt_q + 5'd1;
          else      st_q  <= C_MON;
        end
        C_MON: begin
          if ((days_q < {13'd0, mlen}) || (mon_q == 4'd11)) begin
            st_q   <= C_IDLE;
            done_q <= 1'b1;
          end
        end
        default: st_q <= C_IDLE;
      endcase
    end
  end

  assign sts_o.done = done_q;
  assign year_o     = year_q;
  assign month_o    = mon_q;
  assign day_o      = day_q;

  // The quadrennial count never passes its cap.
  a_quad_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == C_QUAD |-> cnt_q <= 5'd24)
    else $error("four-year count past its cap");

  // Completion comes only out of the month scan.
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(st_q) == C_MON)
    else $error("calendar done outside month scan");

  // A result month is always a real month.
  a_month_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (mon_q >= 4'd1) && (mon_q <= 4'd12))
    else $error("month out of range");

endmodule

>>> test/filetime_to_calendar_date_core_tb.sv
// Testbench for the tick-count to calendar date converter, with a built-in date predictor.
module filetime_to_calendar_date_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Calendar constants of the predictor.
  localparam logic [63:0] TICKS_PER_SECOND = 64'd10000000;
  localparam int unsigned FIRST_YEAR       = 1601;
  localparam int unsigned DAYS_PER_YEAR    = 365;
  localparam int unsigned DAYS_PER_4Y      = 4 * 365 + 1;
  localparam int unsigned DAYS_PER_100Y    = DAYS_PER_4Y * 25 - 1;
  localparam int unsigned DAYS_PER_400Y    = DAYS_PER_100Y * 4 + 1;

  // Highest day index whose whole day still fits in 64 bits of ticks.
  localparam int unsigned LAST_FULL_DAY = 21350397;

  localparam int unsigned CYCLE_LIMIT     = 2000000;
  localparam int unsigned SETTLE_CYCLES   = 300;
  localparam int unsigned LONG_HOLD       = 3000;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_date_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // [63:0] tick_count
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;   // [15:0] year, [19:16] month, [24:20] day_of_month,
                               // [29:25] hour, [35:30] minute, [41:36] second

  cal_date_t   pending_dates[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned stall_burst = 0;
  logic        hold_on = 1'b0;

  filetime_to_calendar_date_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Calendar date and time of day of a tick count, computed period by period.
  function automatic cal_date_t calendar_of(input logic [63:0] ticks);
    logic [63:0] t;
    int unsigned days, yr, q, len;
    logic        leap, hit;
    cal_date_t   r;
    t = ticks / TICKS_PER_SECOND;
    r.second = 6'(t % 64'd60);
    t = t / 64'd60;
    r.minute = 6'(t % 64'd60);
    t = t / 64'd60;
    r.hour = 5'(t % 64'd24);
    days = 32'(t / 64'd24);
    // Whole 400-year eras, then centuries, four-year groups and single years.
    // The last period of each size is capped so a leap day stays in its year.
    yr = FIRST_YEAR + (days / DAYS_PER_400Y) * 400;
    days = days % DAYS_PER_400Y;
    q = days / DAYS_PER_100Y;
    if (q == 4) q = 3;
    yr += q * 100;
    days -= q * DAYS_PER_100Y;
    q = days / DAYS_PER_4Y;
    if (q == 25) q = 24;
    yr += q * 4;
    days -= q * DAYS_PER_4Y;
    q = days / DAYS_PER_YEAR;
    if (q == 4) q = 3;
    yr += q;
    days -= q * DAYS_PER_YEAR;
    // Walk the months; an overrun would saturate to December 31.
    leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    r.year  = 16'(yr);
    r.month = 4'd12;
    r.day   = 5'd31;
    hit     = 1'b0;
    for (int m = 0; m < 12; m++) begin
      len = (m == 1) ? (leap ? 29 : 28) :
            (m == 3 || m == 5 || m == 8 || m == 10) ? 30 : 31;
      if (!hit) begin
        if (days < len) begin
          r.month = 4'(m + 1);
          r.day   = 5'(days + 1);
          hit     = 1'b1;
        end else begin
          days -= len;
        end
      end
    end
    return r;
  endfunction

  // Tick count of a given day index and time of day.
  function automatic logic [63:0] ticks_at(input logic [63:0] day_idx, input int unsigned hh,
                                           input int unsigned mm, input int unsigned ss,
                                           input int unsigned frac);
    return (((day_idx * 64'd24 + 64'(hh)) * 64'd60 + 64'(mm)) * 64'd60 + 64'(ss))
           * TICKS_PER_SECOND + 64'(frac);
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    error_count++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Offer one tick count, possibly after an idle gap, and record the expected date.
  task automatic send_ticks(input logic [63:0] ticks);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < sender_idle_pct) gap = $urandom_range(300, 1);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ticks;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_dates.push_back(calendar_of(ticks));
  endtask

  // Stop offering items and wait until every expected date has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_dates.size() != 0) @(posedge clk_i);
  endtask

  // Random tick count: raw 64-bit values, any day, period edges and early years.
  function automatic logic [63:0] random_ticks();
    logic [63:0] day_idx;
    int unsigned off;
    case ($urandom_range(3))
      0: return {$urandom, $urandom};
      1: day_idx = 64'($urandom_range(LAST_FULL_DAY, 0));
      2: begin
        off = $urandom_range(3) * DAYS_PER_100Y + $urandom_range(24) * DAYS_PER_4Y
              + $urandom_range(3) * DAYS_PER_YEAR
              + ($urandom_range(1) ? $urandom_range(61, 55) : $urandom_range(366, 360));
        day_idx = 64'($urandom_range(144, 0)) * 64'(DAYS_PER_400Y) + 64'(off);
      end
      default: day_idx = 64'($urandom_range(3000, 0));
    endcase
    return ticks_at(day_idx, $urandom_range(23), $urandom_range(59), $urandom_range(59),
                    $urandom_range(9999999));
  endfunction

  // Field extremes, leap days, capped periods and the largest inputs.
  task automatic test_directed();
    logic [63:0] cases[$];
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    cases = '{64'd0, 64'd9999999, 64'd10000000,
              ticks_at(0, 23, 59, 59, 9999999), ticks_at(0, 0, 59, 0, 0),
              ticks_at(364, 12, 0, 0, 0), ticks_at(365, 0, 0, 0, 0),
              ticks_at(1154, 6, 30, 30, 0), ticks_at(1460, 23, 59, 59, 0),
              ticks_at(1461, 0, 0, 0, 0), ticks_at(36217, 1, 2, 3, 4),
              ticks_at(36218, 0, 0, 0, 0), ticks_at(145790, 12, 0, 0, 0),
              ticks_at(146096, 23, 59, 59, 9999999), ticks_at(146097, 0, 0, 0, 0),
              ticks_at(LAST_FULL_DAY, 23, 59, 59, 9999999),
              64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
              64'h7FFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555,
              64'hAAAA_AAAA_AAAA_AAAA};
    foreach (cases[i]) send_ticks(cases[i]);
    drain_results();
  endtask

  // Random tick counts under one idling setting.
  task automatic test_random(input int unsigned n, input int unsigned idle_pct,
                             input int unsigned stall_pct);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (n) send_ticks(random_ticks());
    drain_results();
  endtask

  // Receiver holds off for a long stretch so the block fills and stalls its input.
  task automatic test_backpressure();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    fork
      begin
        hold_on <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_on <= 1'b0;
      end
    join_none
    repeat (8) send_ticks(random_ticks());
    drain_results();
  endtask

  // Receiver ready: random stalls, occasional long bursts, and the pressure hold.
  always @(posedge clk_i) begin
    if (stall_burst != 0) begin
      stall_burst   <= stall_burst - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_on) begin
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(99) < receiver_stall_pct) begin
      m_axis_tready <= 1'b0;
      if ($urandom_range(31) == 0) stall_burst <= $urandom_range(300, 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expected date.
  always @(posedge clk_i) begin
    cal_date_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, 0);
      end else begin
        want = pending_dates.pop_front();
        if (m_axis_tdata[15:0] !== want.year)
          report_mismatch("year", m_axis_tdata[15:0], want.year);
        if (m_axis_tdata[19:16] !== want.month)
          report_mismatch("month", m_axis_tdata[19:16], want.month);
        if (m_axis_tdata[24:20] !== want.day)
          report_mismatch("day_of_month", m_axis_tdata[24:20], want.day);
        if (m_axis_tdata[29:25] !== want.hour)
          report_mismatch("hour", m_axis_tdata[29:25], want.hour);
        if (m_axis_tdata[35:30] !== want.minute)
          report_mismatch("minute", m_axis_tdata[35:30], want.minute);
        if (m_axis_tdata[41:36] !== want.second)
          report_mismatch("second", m_axis_tdata[41:36], want.second);
        if (m_axis_tdata[47:42] !== 6'd0)
          report_mismatch("padding", m_axis_tdata[47:42], 0);
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Reset, then the test sequence and the final verdict.
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 64'd0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(110, 0, 0);
    test_random(105, 56, 0);
    test_random(105, 0, 56);
    test_random(105, 9, 9);
    test_backpressure();

    // Let any stray result surface before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_dates.size() != 0)
      report_mismatch("results still missing", pending_dates.size(), 0);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
